>>> design/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Field structs, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int NUM_FRAMES         = 1024;
    localparam int MAX_REQUEST_FRAMES = 64;

    // map organization: one word of busy bits read per cycle
    localparam int WORD_W      = 32;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int NUM_WORDS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POP_W       = $clog2(WORD_W + 1);

    // item field widths
    localparam int CMD_W     = 2;
    localparam int SIZE_W    = 24;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int FRAME_W   = 10;

    // configuration
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_FRAMES_W = 11;
    localparam int CFG_FSL2_W   = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE_LOG2 = CFG_IDX_W'(1);
    localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = CFG_FRAMES_W'(1024);
    localparam logic [CFG_FSL2_W-1:0]   FSL2_RESET   = CFG_FSL2_W'(12);

    // frame count width: holds the register value and NUM_FRAMES
    localparam int FCNT_W = $clog2(NUM_FRAMES + 1);
    localparam int LIM_W  = (FCNT_W > CFG_FRAMES_W) ? FCNT_W : CFG_FRAMES_W;

    // request counts
    localparam int NEED_W = $clog2(MAX_REQUEST_FRAMES + 1);
    localparam int CNT_W  = ((NEED_W > POP_W) ? NEED_W : POP_W) + 1;

    localparam logic [CMD_W-1:0] CMD_PROBE     = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_MARK_BUSY = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_MARK_FREE = CMD_W'(2);

    localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_SHORT  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_LIMIT  = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_BADIDX = STATUS_W'(3);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SIZE_W-1:0]  process_size;
        logic [INDEX_W-1:0] frame_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                frame_valid;
        logic [FRAME_W-1:0]  found_frame;
        logic                last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_COUNT,
        S_SHORT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SEL_FRAME,
        SEL_DONE,
        SEL_SHORT,
        SEL_LIMIT,
        SEL_BADIDX
    } t_out_sel;

    typedef struct packed {
        logic     capture;    // latch the input item
        logic     cnt_start;  // word 0, count 0
        logic     cnt_step;   // add free bits of current word, next word
        logic     emit_init;  // word 0, remaining = need
        logic     emit_load;  // load free bits of current word
        logic     emit_bit;   // clear lowest free bit after it is sent
        logic     map_write;  // apply mark command
        logic     out_write;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             need_zero;
        logic             need_over;
        logic             limit_zero;
        logic             idx_bad;
        logic             enough;
        logic             last_word;
        logic             free_zero;
        logic             remain_one;
        logic             out_free;
    } t_dp_stat;

    // popcount of one byte
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, v[i]};
        end
        return s;
    endfunction

    // popcount of a map word, bytes summed one after another
    function automatic logic [POP_W-1:0] pop_word(input logic [WORD_W-1:0] v);
        logic [POP_W-1:0] s;
        s = '0;
        for (int b = 0; b < WORD_W / 8; b++) begin
            s = s + POP_W'(pop8(v[b*8 +: 8]));
        end
        return s;
    endfunction

endpackage

>>> design/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl: command sequencer of the frame bitmap allocator
// Decodes the captured item and steps the count and emit passes of a probe.
// ----------------------------------------------------------------------------
module fba_ctrl
    import fba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.out_sel = SEL_DONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.cmd)
                    CMD_PROBE: begin
                        if (i_stat.need_over || i_stat.need_zero || i_stat.limit_zero) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_write = 1'b1;
                                if (i_stat.need_over) begin
                                    o_cmd.out_sel = SEL_LIMIT;
                                end else if (i_stat.need_zero) begin
                                    o_cmd.out_sel = SEL_DONE;
                                end else begin
                                    o_cmd.out_sel = SEL_SHORT;
                                end
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_cmd.cnt_start = 1'b1;
                            n_state         = S_COUNT;
                        end
                    end
                    CMD_MARK_BUSY, CMD_MARK_FREE: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_write = 1'b1;
                            if (i_stat.idx_bad) begin
                                o_cmd.out_sel = SEL_BADIDX;
                            end else begin
                                o_cmd.map_write = 1'b1;
                                o_cmd.out_sel   = SEL_DONE;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        // unknown command: dropped without a result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_COUNT: begin
                if (i_stat.enough) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end else if (i_stat.last_word) begin
                    n_state = S_SHORT;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_SHORT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_write = 1'b1;
                    o_cmd.out_sel   = SEL_SHORT;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.free_zero) begin
                    o_cmd.emit_load = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_bit  = 1'b1;
                    o_cmd.out_write = 1'b1;
                    o_cmd.out_sel   = SEL_FRAME;
                    if (i_stat.remain_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath: busy map, config registers and result register
// Holds the map as words of busy bits, counts and picks free frames word by
// word under control of the sequencer.
// ----------------------------------------------------------------------------
module fba_datapath
    import fba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic [WORD_W-1:0]       r_map [NUM_WORDS];
    logic [CFG_FRAMES_W-1:0] r_frames;
    logic [CFG_FSL2_W-1:0]   r_fsl2;

    logic [CMD_W-1:0]        r_cmd;
    logic [INDEX_W-1:0]      r_idx;
    logic [NEED_W-1:0]       r_need;
    logic                    r_need_zero;
    logic                    r_need_over;

    logic [WORD_IDX_W-1:0]   r_word;
    logic [WORD_IDX_W-1:0]   r_load_word;
    logic [CNT_W-1:0]        r_cnt;
    logic [WORD_W-1:0]       r_free;
    logic [NEED_W-1:0]       r_remain;

    logic                    r_out_valid;
    t_out_item               r_out_item;
    t_out_item               n_out_item;

    logic [LIM_W-1:0]        limit;
    logic [LIM_W-1:0]        lim_m1;
    logic [LIM_W-1:0]        base;
    logic [LIM_W-1:0]        rem;
    logic [WORD_W-1:0]       lim_mask;
    logic [WORD_W-1:0]       cur_free;
    logic [POP_W-1:0]        pop;
    logic [BIT_IDX_W-1:0]    pri;
    logic [LIM_W-1:0]        found;
    logic [LIM_W-1:0]        idx_ext;
    logic [WORD_IDX_W-1:0]   m_word;
    logic [BIT_IDX_W-1:0]    m_bit;

    logic [SIZE_W-1:0]       quot;
    logic                    rem_nz;
    logic [SIZE_W-1:0]       need_full;

    logic                    out_free;

    // frame count in use, clipped to the map size
    assign limit  = (LIM_W'(r_frames) > LIM_W'(NUM_FRAMES)) ? LIM_W'(NUM_FRAMES)
                                                             : LIM_W'(r_frames);
    assign lim_m1 = limit - LIM_W'(1);
    assign base   = LIM_W'({r_word, {BIT_IDX_W{1'b0}}});
    assign rem    = limit - base;

    always_comb begin
        if (limit <= base) begin
            lim_mask = '0;
        end else if (rem >= LIM_W'(WORD_W)) begin
            lim_mask = '1;
        end else begin
            lim_mask = ~({WORD_W{1'b1}} << rem[BIT_IDX_W-1:0]);
        end
    end

    assign cur_free = ~r_map[r_word] & lim_mask;
    assign pop      = pop_word(cur_free);

    // lowest free bit of the loaded word
    always_comb begin
        pri = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                pri = BIT_IDX_W'(i);
            end
        end
    end

    assign found   = LIM_W'({r_load_word, pri});
    assign idx_ext = LIM_W'(r_idx);
    assign m_word  = idx_ext[BIT_IDX_W +: WORD_IDX_W];
    assign m_bit   = idx_ext[BIT_IDX_W-1:0];

    // frames needed: size rounded up to whole frames
    assign quot      = i_in_item.process_size >> r_fsl2;
    assign rem_nz    = |(i_in_item.process_size & ~({SIZE_W{1'b1}} << r_fsl2));
    assign need_full = quot + SIZE_W'(rem_nz);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.cmd        = r_cmd;
        o_stat.need_zero  = r_need_zero;
        o_stat.need_over  = r_need_over;
        o_stat.limit_zero = (limit == '0);
        o_stat.idx_bad    = (idx_ext >= limit);
        o_stat.enough     = (r_cnt + CNT_W'(pop)) >= CNT_W'(r_need);
        o_stat.last_word  = (r_word == lim_m1[BIT_IDX_W +: WORD_IDX_W]);
        o_stat.free_zero  = (r_free == '0);
        o_stat.remain_one = (r_remain == NEED_W'(1));
        o_stat.out_free   = out_free;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
            r_fsl2   <= FSL2_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAMES_IN_USE:   r_frames <= i_cfg_data[CFG_FRAMES_W-1:0];
                CFG_FRAME_SIZE_LOG2: r_fsl2   <= i_cfg_data[CFG_FSL2_W-1:0];
                default: ;
            endcase
        end
    end

    // busy map, all frames free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_map[w] <= '0;
            end
        end else if (i_cmd.map_write) begin
            r_map[m_word][m_bit] <= (r_cmd == CMD_MARK_BUSY);
        end
    end

    // captured item and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd       <= i_in_item.cmd;
            r_idx       <= i_in_item.frame_index;
            r_need      <= need_full[NEED_W-1:0];
            r_need_zero <= (need_full == '0);
            r_need_over <= (need_full > SIZE_W'(MAX_REQUEST_FRAMES));
        end
        if (i_cmd.cnt_start) begin
            r_word <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.cnt_step) begin
            r_word <= r_word + WORD_IDX_W'(1);
            r_cnt  <= r_cnt + CNT_W'(pop);
        end else if (i_cmd.emit_init) begin
            r_word   <= '0;
            r_free   <= '0;
            r_remain <= r_need;
        end else if (i_cmd.emit_load) begin
            r_load_word <= r_word;
            r_free      <= cur_free;
            r_word      <= r_word + WORD_IDX_W'(1);
        end else if (i_cmd.emit_bit) begin
            r_free[pri] <= 1'b0;
            r_remain    <= r_remain - NEED_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_item      = '0;
        n_out_item.last = 1'b1;
        case (i_cmd.out_sel)
            SEL_FRAME: begin
                n_out_item.status      = ST_OK;
                n_out_item.frame_valid = 1'b1;
                n_out_item.found_frame = found[FRAME_W-1:0];
                n_out_item.last        = (r_remain == NEED_W'(1));
            end
            SEL_DONE:   n_out_item.status = ST_OK;
            SEL_SHORT:  n_out_item.status = ST_SHORT;
            SEL_LIMIT:  n_out_item.status = ST_LIMIT;
            SEL_BADIDX: n_out_item.status = ST_BADIDX;
            default:    n_out_item.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: bitmap page-frame allocator
// One busy bit per frame; probes list the lowest free frames, mark commands
// set or clear a single frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) takes one command item.
//   Output channel (o_out_valid/i_out_ready, o_out_item) gives its results;
//   a probe gives one result per frame found, last set on the final one.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; write it only
//   while no item is in flight.
// Timing:
//   Mark commands and single-result probes: the item is captured, the result
//   is registered from the decide state, then the next item can be taken.
//   Full probes: the count pass reads one 32-bit map word per cycle until
//   enough free frames are seen, then the emit pass re-reads the words and
//   sends one frame per cycle while the receiver is ready; each word it
//   loads takes a load step of its own.
// Reset (synchronous, active low) frees every frame and restores the config
// registers. A stalled receiver holds the result register and the scan
// pauses; a new item is taken while the last result of the previous one
// still waits.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator
    import fba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> design/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker: port-level checks of the frame bitmap allocator
// Watches the top-level ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module fba_checker
    import fba_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a reported frame always carries ok status
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_valid |-> o_out_item.status == ST_OK)
        else $error("frame reported with error status");

    // results without a frame are single and carry frame zero
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.frame_valid
            |-> o_out_item.last && o_out_item.found_frame == '0)
        else $error("bad single result");

    // one item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken back to back");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

>>> verif/frame_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// testbench: frame bitmap allocator
// Directed checks of probe, mark and config corners, then random command
// traffic under several idling phases. A shadow busy map predicts every
// result, and each result is compared in order against the predicted stream.
// ----------------------------------------------------------------------------
module testbench;
    import fba_pkg::*;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ITEMS_PER_PHASE = 105;
    localparam logic [CMD_W-1:0]     CMD_UNUSED      = CMD_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_FRAME_SIZE_LOG2 + 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;

    // shadow of the block state and registers
    logic [NUM_FRAMES-1:0]   busy_shadow;
    logic [CFG_FRAMES_W-1:0] frames_cfg;
    logic [CFG_FSL2_W-1:0]   fsl2_cfg;

    t_out_item   awaited_results[$];
    int          mismatches;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int unsigned cycle_count = 0;

    frame_bitmap_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Works out the results of one accepted command and updates the shadow map.
    task automatic predict_command(input t_in_item it);
        int unsigned        lim;
        longint unsigned    need;
        logic [FRAME_W-1:0] hits[MAX_REQUEST_FRAMES];
        int                 got;
        t_out_item          r;
        lim = (frames_cfg < NUM_FRAMES) ? frames_cfg : NUM_FRAMES;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (it.cmd)
            CMD_PROBE: begin
                need = (64'(it.process_size) + (64'd1 << fsl2_cfg) - 64'd1) >> fsl2_cfg;
                got = 0;
                if (need > MAX_REQUEST_FRAMES) begin
                    r.status = ST_LIMIT;
                end else if (need != 0) begin
                    for (int i = 0; i < lim && got < need; i++) begin
                        if (!busy_shadow[i]) begin
                            hits[got] = FRAME_W'(i);
                            got++;
                        end
                    end
                    // no partial list when the map runs short
                    if (got < need) begin
                        r.status = ST_SHORT;
                        got = 0;
                    end
                end
                if (got == 0) begin
                    awaited_results.push_back(r);
                end else begin
                    for (int k = 0; k < got; k++) begin
                        r.frame_valid = 1'b1;
                        r.found_frame = hits[k];
                        r.last = (k == got - 1);
                        awaited_results.push_back(r);
                    end
                end
            end
            CMD_MARK_BUSY, CMD_MARK_FREE: begin
                if (it.frame_index >= lim) begin
                    r.status = ST_BADIDX;
                end else begin
                    busy_shadow[it.frame_index] = (it.cmd == CMD_MARK_BUSY);
                end
                awaited_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Checks each accepted result against the oldest prediction; drives ready.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d frame_valid %0d found_frame %0d last %0d",
                       out_item.status, out_item.frame_valid, out_item.found_frame,
                       out_item.last);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_item.status);
                    mismatches++;
                end
                if (out_item.frame_valid !== want.frame_valid) begin
                    $error("frame_valid: expected %0d, actual %0d",
                           want.frame_valid, out_item.frame_valid);
                    mismatches++;
                end
                if (out_item.found_frame !== want.found_frame) begin
                    $error("found_frame: expected %0d, actual %0d",
                           want.found_frame, out_item.found_frame);
                    mismatches++;
                end
                if (out_item.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, out_item.last);
                    mismatches++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic t_in_item make_item(input logic [CMD_W-1:0] cmd,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [INDEX_W-1:0] idx);
        t_in_item it;
        it.cmd = cmd;
        it.process_size = size;
        it.frame_index = idx;
        return it;
    endfunction

    // Entered and left at a rising edge; valid stays high between back-to-back items.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        predict_command(it);
    endtask

    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Writes both registers, then an unmapped index that must change nothing.
    task automatic configure(input logic [CFG_DATA_W-1:0] frames_data,
                             input logic [CFG_DATA_W-1:0] fsl2_data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAMES_IN_USE;
        cfg_data  <= frames_data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        frames_cfg = frames_data[CFG_FRAMES_W-1:0];
        cfg_index <= CFG_FRAME_SIZE_LOG2;
        cfg_data  <= fsl2_data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        fsl2_cfg = fsl2_data[CFG_FSL2_W-1:0];
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, (1 << CFG_IDX_W) - 1));
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset config: 1024 frames of 4 KiB.
    task automatic test_reset_defaults();
        send_item(make_item(CMD_PROBE, 24'd0, 10'd0));
        send_item(make_item(CMD_PROBE, 24'd1, 10'd1023));
        send_item(make_item(CMD_PROBE, 24'd262144, 10'd0));
        send_item(make_item(CMD_PROBE, 24'd262145, 10'd0));
        send_item(make_item(CMD_PROBE, 24'hFFFFFF, 10'd0));
        send_item(make_item(CMD_UNUSED, 24'hFFFFFF, 10'd1023));
    endtask

    task automatic test_mark_commands();
        send_item(make_item(CMD_MARK_BUSY, 24'd0, 10'd0));
        send_item(make_item(CMD_MARK_BUSY, 24'hFFFFFF, 10'd1023));
        send_item(make_item(CMD_MARK_BUSY, 24'd0, 10'd33));
        send_item(make_item(CMD_PROBE, 24'd12288, 10'd0));
        send_item(make_item(CMD_MARK_FREE, 24'd0, 10'd0));
        send_item(make_item(CMD_MARK_FREE, 24'd0, 10'd1023));
        send_item(make_item(CMD_PROBE, 24'd8192, 10'd0));
    endtask

    task automatic test_config_extremes();
        // no frames managed: nonzero probes fail short, marks are rejected
        wait_idle(DRAIN_CYCLES);
        configure(11'd0, 11'd4);
        send_item(make_item(CMD_PROBE, 24'd1, 10'd0));
        send_item(make_item(CMD_PROBE, 24'd0, 10'd0));
        send_item(make_item(CMD_MARK_BUSY, 24'd0, 10'd0));
        send_item(make_item(CMD_MARK_FREE, 24'd0, 10'd1023));
        // count above the map size clamps; one-byte frames
        wait_idle(DRAIN_CYCLES);
        configure(11'd2047, 11'd0);
        send_item(make_item(CMD_PROBE, 24'd64, 10'd0));
        send_item(make_item(CMD_PROBE, 24'd65, 10'd0));
        send_item(make_item(CMD_MARK_BUSY, 24'd0, 10'd1023));
        // huge frames: any nonzero size needs one frame
        wait_idle(DRAIN_CYCLES);
        configure(11'd8, 11'd31);
        send_item(make_item(CMD_PROBE, 24'hFFFFFF, 10'd0));
        send_item(make_item(CMD_MARK_BUSY, 24'd0, 10'd8));
    endtask

    task automatic test_short_supply();
        sender_idle_pct = 29;
        recv_stall_pct  = 29;
        wait_idle(DRAIN_CYCLES);
        configure(11'd8, 11'd16);
        send_item(make_item(CMD_PROBE, 24'd524288, 10'd0));
        send_item(make_item(CMD_PROBE, 24'd589824, 10'd0));
    endtask

    task automatic test_random_traffic();
        t_in_item        it;
        int              counted;
        int              target;
        int              pick;
        int unsigned     lim;
        int unsigned     sh;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned max_size;
        max_size = (64'd1 << SIZE_W) - 64'd1;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle(DRAIN_CYCLES);
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    configure(CFG_DATA_W'(FRAMES_RESET),
                              {6'($urandom), FSL2_RESET});
                end
                1: begin
                    sender_idle_pct = 80;
                    recv_stall_pct  = 0;
                    configure(CFG_DATA_W'($urandom_range(1, 200)),
                              CFG_DATA_W'($urandom_range(4, 8)));
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 80;
                    configure(CFG_DATA_W'($urandom_range(900, 2047)),
                              {6'($urandom), 5'd16});
                end
                default: begin
                    sender_idle_pct = 29;
                    recv_stall_pct  = 29;
                    configure(CFG_DATA_W'($urandom_range(40, 100)),
                              CFG_DATA_W'($urandom_range(0, 10)));
                end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                lim = (frames_cfg < NUM_FRAMES) ? frames_cfg : NUM_FRAMES;
                sh = fsl2_cfg;
                it.process_size = SIZE_W'($urandom);
                it.frame_index = INDEX_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    it.cmd = CMD_PROBE;
                    pick = $urandom_range(0, 99);
                    if (pick < 10) target = 0;
                    else if (pick < 20) target = $urandom_range(56, MAX_REQUEST_FRAMES);
                    else if (pick < 28) target = $urandom_range(MAX_REQUEST_FRAMES + 1, 80);
                    else if (pick < 90) target = $urandom_range(1, 20);
                    else target = -1;
                    // pick a byte size that rounds up to the wanted frame count
                    if (target >= 0) begin
                        lo = (target == 0) ? 64'd0 : ((64'(target) - 64'd1) << sh) + 64'd1;
                        hi = 64'(target) << sh;
                        if (hi > max_size) hi = max_size;
                        if (lo <= hi) begin
                            it.process_size = SIZE_W'(lo + ($urandom % (hi - lo + 64'd1)));
                        end
                    end
                end else if (pick < 92) begin
                    it.cmd = (pick < 70) ? CMD_MARK_BUSY : CMD_MARK_FREE;
                    // crowd the low words so probes have to scan further
                    if (lim > 0 && $urandom_range(0, 9) != 0) begin
                        if ($urandom_range(0, 1) != 0) begin
                            it.frame_index = INDEX_W'($urandom_range(0,
                                                     (lim > 96) ? 95 : lim - 1));
                        end else begin
                            it.frame_index = INDEX_W'($urandom_range(0, lim - 1));
                        end
                    end
                end else if (pick < 95) begin
                    it.cmd = CMD_UNUSED;
                end else begin
                    it.cmd = CMD_W'($urandom);
                end
                send_item(it);
                if (it.cmd != CMD_UNUSED) begin
                    counted++;
                    if (counted == ITEMS_PER_PHASE / 2) wait_idle(0);
                end
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_item         = '0;
        out_ready       = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        mismatches      = 0;
        busy_shadow     = '0;
        frames_cfg      = FRAMES_RESET;
        fsl2_cfg        = FSL2_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_mark_commands();
        test_config_extremes();
        test_short_supply();
        test_random_traffic();
        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
